>>> rtl/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int REQ_W      = 3;
  localparam int ITEM_W     = 32;
  localparam int OUT_DATA_W = 32;
  localparam int STATUS_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

>>> rtl/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/dq_ctrl.sv
module dq_ctrl #(
  parameter int DEPTH      = dq_pkg::DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH,
  localparam int IdxW = $clog2(DEPTH),
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dq_pkg::REQ_W-1:0]        req_type,
  input  logic [dq_pkg::ITEM_W-1:0]       item_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dq_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [CntW-1:0]                 occupancy,
  output dq_pkg::status_t                 status,
  output logic                            wr_en,
  output logic [IdxW-1:0]                 wr_addr,
  output logic [DATA_WIDTH-1:0]           wr_data,
  output logic                            rd_en,
  output logic [IdxW-1:0]                 rd_addr,
  input  logic [DATA_WIDTH-1:0]           rd_data
);

  localparam int SumW = CntW + 1;

  dq_pkg::state_t               state, state_next;
  logic [IdxW-1:0]              front, front_next;
  logic [CntW-1:0]              count, count_next;
  logic [CntW-1:0]              pend_occ, pend_occ_next;
  logic                         out_valid_next;
  logic [dq_pkg::OUT_DATA_W-1:0] out_data_next;
  logic [CntW-1:0]              occupancy_next;
  dq_pkg::status_t              status_next;

  logic            accept;
  logic            full;
  logic            empty;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] front_inc;
  logic [SumW-1:0] tail_sum;
  logic [SumW-1:0] back_sum;
  logic [IdxW-1:0] tail_slot;
  logic [IdxW-1:0] back_slot;
  logic [63:0]     item_wide;
  logic [63:0]     rd_wide;

  assign in_ready  = (state == dq_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count == CntW'(DEPTH));
  assign empty     = (count == '0);
  assign item_wide = 64'(item_data);
  assign rd_wide   = 64'(rd_data);
  assign wr_data   = item_wide[DATA_WIDTH-1:0];

  assign front_dec = (front == '0) ? IdxW'(DEPTH - 1) : front - IdxW'(1);
  assign front_inc = (front == IdxW'(DEPTH - 1)) ? '0 : front + IdxW'(1);

  assign tail_sum  = SumW'(front) + SumW'(count);
  assign back_sum  = tail_sum - SumW'(1);
  assign tail_slot = (tail_sum >= SumW'(DEPTH)) ? IdxW'(tail_sum - SumW'(DEPTH))
                                                : IdxW'(tail_sum);
  assign back_slot = (back_sum >= SumW'(DEPTH)) ? IdxW'(back_sum - SumW'(DEPTH))
                                                : IdxW'(back_sum);

  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    pend_occ_next  = pend_occ;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    occupancy_next = occupancy;
    status_next    = status;
    wr_en          = 1'b0;
    wr_addr        = tail_slot;
    rd_en          = 1'b0;
    rd_addr        = front;

    case (state)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          out_data_next  = '0;
          occupancy_next = count;
          status_next    = dq_pkg::STAT_OK;
          if (req_type inside {dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK}) begin
            out_valid_next = 1'b1;
            if (full) begin
              status_next = dq_pkg::STAT_FULL;
            end else begin
              wr_en = 1'b1;
              if (req_type == dq_pkg::REQ_PUSH_FRONT) begin
                wr_addr    = front_dec;
                front_next = front_dec;
              end
              count_next     = count + CntW'(1);
              occupancy_next = count + CntW'(1);
            end
          end else if (req_type inside {[dq_pkg::REQ_POP_FRONT:dq_pkg::REQ_PEEK_BACK]}) begin
            if (empty) begin
              out_valid_next = 1'b1;
              status_next    = dq_pkg::STAT_EMPTY;
            end else begin
              rd_en      = 1'b1;
              state_next = dq_pkg::ST_READ;
              if (req_type inside {dq_pkg::REQ_POP_BACK, dq_pkg::REQ_PEEK_BACK}) begin
                rd_addr = back_slot;
              end
              pend_occ_next = count;
              if (req_type == dq_pkg::REQ_POP_FRONT) begin
                front_next    = front_inc;
                count_next    = count - CntW'(1);
                pend_occ_next = count - CntW'(1);
              end else if (req_type == dq_pkg::REQ_POP_BACK) begin
                count_next    = count - CntW'(1);
                pend_occ_next = count - CntW'(1);
              end
            end
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      dq_pkg::ST_READ: begin
        out_valid_next = 1'b1;
        out_data_next  = rd_wide[dq_pkg::OUT_DATA_W-1:0];
        occupancy_next = pend_occ;
        status_next    = dq_pkg::STAT_OK;
        state_next     = dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dq_pkg::ST_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_occ  <= pend_occ_next;
    out_data  <= out_data_next;
    occupancy <= occupancy_next;
    status    <= status_next;
  end

endmodule

>>> rtl/double_ended_queue.sv
// Channel   Direction  Carries
// s_axis    in         tuser: req_type; tdata: item_data
// m_axis    out        tdata: out_data, occupancy; tuser: status
//
// For pushes and failed requests the result is registered in the cycle after acceptance.
// Successful pops and peeks go through the registered read of the ring memory and the read state first.
// One request is in flight at a time; a new one is taken once the result register is free.
// Reset clears the front index, the count and the result valid flag; the ring is not cleared.
// A stalled result holds the input off until it is taken.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH,
  localparam int IdxW   = $clog2(DEPTH),
  localparam int CntW   = $clog2(DEPTH + 1),
  localparam int TdataW = ((dq_pkg::OUT_DATA_W + CntW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dq_pkg::ITEM_W-1:0]     s_tdata,   // item_data
  input  logic [dq_pkg::REQ_W-1:0]      s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [TdataW-1:0]             m_tdata,   // out_data, occupancy, zero fill
  output logic [dq_pkg::STATUS_W-1:0]   m_tuser    // status
);

  logic [dq_pkg::OUT_DATA_W-1:0] out_data;
  logic [CntW-1:0]               occupancy;
  dq_pkg::status_t               status;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_addr;
  logic [DATA_WIDTH-1:0]         wr_data;
  logic                          rd_en;
  logic [IdxW-1:0]               rd_addr;
  logic [DATA_WIDTH-1:0]         rd_data;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .item_data (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .occupancy (occupancy),
    .status    (status),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_tdata = TdataW'({occupancy, out_data});
  assign m_tuser = status;

endmodule
